[design/ftda_pkg.sv]
package ftda_pkg;

  localparam int IntBits   = 31;
  localparam int MantBits  = 23;
  localparam int FracBits  = 24;
  localparam int NumDigits = 10;
  localparam int ConvSteps = IntBits;
  localparam int CntW      = $clog2(ConvSteps);
  localparam int DigIdxW   = $clog2(NumDigits);
  localparam int NdW       = 4;
  localparam int ShW       = 5;

  localparam logic [7:0] ExpBias     = 8'd127;
  localparam logic [7:0] ExpFieldMin = 8'd104;
  localparam logic [7:0] ExpFieldMax = 8'd157;

  localparam logic [NdW-1:0] MaxDecimals   = 4'd9;
  localparam logic [NdW-1:0] ZeroDecimals  = 4'd2;
  localparam logic [NdW-1:0] ResetDecimals = 4'd2;
  localparam logic [NdW-1:0] OneDigit      = 4'd1;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiPoint = 8'h2e;
  localparam logic [7:0] ErrorChar  = 8'h00;

  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StConvert,
    StLocate,
    StInt,
    StPoint,
    StFrac,
    StError
  } state_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic locate;
    logic emit_int;
    logic emit_point;
    logic emit_frac;
    logic emit_err;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic ipart_zero;
    logic conv_done;
    logic int_last;
    logic nd_zero;
    logic frac_last;
  } status_t;

endpackage

[design/float_to_decimal_ascii.sv]
// Channel  Direction  Signals                                  Transaction
// input    in         start, busy, float_bits_i                start & !busy
// result   out        result_strobe_o, character_o,            one cycle per strobe
//                     is_last_o, error_o
// config   in         cfg_valid_i, cfg_ready_o, cfg_data_i     valid & ready
//
// Per value: load and decode, then the double-dabble conversion if the
// integer part is nonzero, then a search for the leading digit, then one
// character per cycle (up to 20). Out-of-range values give their single
// error result. busy drops while the last character is on the result port.
// Reset clears the FSM, the strobe and sets num_decimals to 2. Results
// cannot be stalled.
module float_to_decimal_ascii import ftda_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  logic [31:0]    float_bits_i,
  output logic           result_strobe_o,
  output logic [7:0]     character_o,
  output logic           is_last_o,
  output logic           error_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [NdW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;
  logic    busy_int;

  assign busy        = busy_int;
  assign cfg_ready_o = !busy_int;

  ftda_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_int)
  );

  ftda_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && !busy_int),
    .cfg_data_i   (cfg_data_i),
    .float_bits_i (float_bits_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .character_o  (character_o),
    .is_last_o    (is_last_o),
    .error_o      (error_o),
    .strobe_o     (result_strobe_o)
  );

endmodule

[design/ftda_ctrl.sv]
module ftda_ctrl import ftda_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) state_d = StDecide;
      end
      StDecide: begin
        if (status_i.err) state_d = StError;
        else if (status_i.ipart_zero) state_d = StLocate;
        else state_d = StConvert;
      end
      StConvert: begin
        if (status_i.conv_done) state_d = StLocate;
      end
      StLocate: state_d = StInt;
      StInt: begin
        if (status_i.int_last) state_d = StPoint;
      end
      StPoint: begin
        state_d = status_i.nd_zero ? StIdle : StFrac;
      end
      StFrac: begin
        if (status_i.frac_last) state_d = StIdle;
      end
      StError: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle:    cmd_o.load = start_i;
      StConvert: cmd_o.conv_step = 1'b1;
      StLocate:  cmd_o.locate = 1'b1;
      StInt:     cmd_o.emit_int = 1'b1;
      StPoint: begin
        cmd_o.emit_point = 1'b1;
        cmd_o.last       = status_i.nd_zero;
      end
      StFrac: begin
        cmd_o.emit_frac = 1'b1;
        cmd_o.last      = status_i.frac_last;
      end
      StError: begin
        cmd_o.emit_err = 1'b1;
        cmd_o.last     = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != StIdle);

endmodule

[design/ftda_datapath.sv]
module ftda_datapath import ftda_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [NdW-1:0] cfg_data_i,
  input  logic [31:0]    float_bits_i,
  input  cmd_t           cmd_i,
  output status_t        status_o,
  output logic [7:0]     character_o,
  output logic           is_last_o,
  output logic           error_o,
  output logic           strobe_o
);

  // input decode
  logic [7:0]                  efield;
  logic [MantBits:0]           mant;
  logic                        is_zero;
  logic                        in_range;
  logic                        exp_pos;
  logic [7:0]                  sh_l_full;
  logic [7:0]                  sh_r_full;
  logic [IntBits+MantBits-1:0] wide;
  logic [IntBits-1:0]          ipart_ld;
  logic [FracBits-1:0]         frac_ld;
  logic [NdW-1:0]              nd_ld;

  logic [NdW-1:0]                   num_dec_q;
  logic                             err_q;
  logic [IntBits-1:0]               ipart_q;
  logic [NumDigits-1:0][3:0]        bcd_q;
  logic [FracBits-1:0]              frac_q;
  logic [NdW-1:0]                   nd_q;
  logic [CntW-1:0]                  cnt_q;
  logic [DigIdxW-1:0]               idx_q;
  logic                             strobe_q;
  logic [7:0]                       char_q;
  logic                             last_q;
  logic                             errout_q;

  logic [NumDigits-1:0][3:0] bcd_adj;
  logic [NumDigits*4-1:0]    bcd_flat;
  logic [DigIdxW-1:0]        msd;
  logic [FracBits+3:0]       prod;

  assign efield    = float_bits_i[30:23];
  assign mant      = {1'b1, float_bits_i[MantBits-1:0]};
  assign is_zero   = (float_bits_i[30:0] == '0);
  assign in_range  = (efield >= ExpFieldMin) && (efield <= ExpFieldMax);
  assign exp_pos   = (efield >= ExpBias);
  assign sh_l_full = efield - ExpBias;
  assign sh_r_full = (ExpBias - 8'd1) - efield;
  assign wide      = {{(IntBits-1){1'b0}}, mant} << sh_l_full[ShW-1:0];

  always_comb begin
    if (is_zero) begin
      ipart_ld = '0;
      frac_ld  = '0;
    end else if (exp_pos) begin
      ipart_ld = wide[IntBits+MantBits-1 -: IntBits];
      frac_ld  = {wide[MantBits-1:0], 1'b0};
    end else begin
      ipart_ld = '0;
      frac_ld  = mant >> sh_r_full[ShW-1:0];
    end
  end

  always_comb begin
    if (is_zero) nd_ld = ZeroDecimals;
    else if (frac_ld == '0) nd_ld = OneDigit;
    else if (num_dec_q > MaxDecimals) nd_ld = MaxDecimals;
    else nd_ld = num_dec_q;
  end

  // double dabble adjust
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  assign bcd_flat = bcd_adj;

  always_comb begin
    msd = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i] != 4'd0) msd = DigIdxW'(i);
    end
  end

  assign prod = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dec_q <= ResetDecimals;
      strobe_q  <= 1'b0;
    end else begin
      if (cfg_we_i) num_dec_q <= cfg_data_i;
      strobe_q <= cmd_i.emit_int | cmd_i.emit_point | cmd_i.emit_frac | cmd_i.emit_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q   <= !is_zero && !in_range;
      ipart_q <= ipart_ld;
      bcd_q   <= '0;
      frac_q  <= frac_ld;
      nd_q    <= nd_ld;
      cnt_q   <= '0;
    end
    if (cmd_i.conv_step) begin
      bcd_q   <= {bcd_flat[NumDigits*4-2:0], ipart_q[IntBits-1]};
      ipart_q <= {ipart_q[IntBits-2:0], 1'b0};
      cnt_q   <= cnt_q + CntW'(1);
    end
    if (cmd_i.locate) idx_q <= msd;
    if (cmd_i.emit_int) idx_q <= idx_q - DigIdxW'(1);
    if (cmd_i.emit_frac) begin
      frac_q <= prod[FracBits-1:0];
      nd_q   <= nd_q - NdW'(1);
    end
    if (cmd_i.emit_int) char_q <= AsciiZero + {4'b0000, bcd_q[idx_q]};
    else if (cmd_i.emit_point) char_q <= AsciiPoint;
    else if (cmd_i.emit_frac) char_q <= AsciiZero + {4'b0000, prod[FracBits+3:FracBits]};
    else if (cmd_i.emit_err) char_q <= ErrorChar;
    last_q   <= cmd_i.last;
    errout_q <= cmd_i.emit_err;
  end

  assign status_o.err        = err_q;
  assign status_o.ipart_zero = (ipart_q == '0);
  assign status_o.conv_done  = (cnt_q == CntW'(ConvSteps - 1));
  assign status_o.int_last   = (idx_q == '0);
  assign status_o.nd_zero    = (nd_q == '0);
  assign status_o.frac_last  = (nd_q == OneDigit);

  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign is_last_o   = last_q;
  assign error_o     = errout_q;

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && errout_q |-> last_q)
    else $error("error result not marked last");

  a_frac_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_frac |-> nd_q != '0)
    else $error("fraction digit emitted with empty count");

  a_msd_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.locate |=> (idx_q == '0) || (bcd_q[idx_q] != 4'd0))
    else $error("leading digit index points at a zero digit");
`endif

endmodule
